// ===== hdl/cau_pkg.sv =====
// Shared types, widths and codes of the complex arithmetic unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cau_pkg;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int MAG_WIDTH  = 2 * DATA_WIDTH;
    localparam int QUO_WIDTH  = DATA_WIDTH + 1;
    localparam int REM_WIDTH  = MAG_WIDTH + QUO_WIDTH + FRAC_BITS;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_WIDTH  = $clog2(FIFO_DEPTH);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [DATA_WIDTH-1:0] x_real;
        logic signed [DATA_WIDTH-1:0] x_imag;
        logic signed [DATA_WIDTH-1:0] y_real;
        logic signed [DATA_WIDTH-1:0] y_imag;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] z_real;
        logic signed [DATA_WIDTH-1:0] z_imag;
        logic [1:0]                   status;
    } out_word_t;

    typedef struct packed {
        in_word_t word;
        logic     div_zero;
    } entry_t;

    typedef struct packed {
        logic         valid;
        logic         pop;
        entry_t       head;
    } queue_if_t;
endpackage

// ===== hdl/cau_front.sv =====
// Front end: takes input words, flags zero divisors, pushes into the queue.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_front
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_data,
    input  logic     full,
    output logic     push,
    output entry_t   entry
);
    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;

    assign in_stall = valid_reg && full;
    assign push     = valid_reg && !full;
    assign entry    = data_reg;

    always_comb
    begin
        valid_next = in_stall ? valid_reg : in_valid;
        data_next.word     = in_data;
        data_next.div_zero = (in_data.operation == OP_DIV) &&
                             (in_data.y_real == '0) && (in_data.y_imag == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
            data_reg <= data_next;
    end
endmodule

// ===== hdl/cau_fifo.sv =====
// Short queue between front and back end.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_fifo
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    entry,
    output logic      full,
    output queue_if_t q_out,
    input  logic      pop
);
    entry_t               mem [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_WIDTH:0]   cnt_reg, cnt_next;
    logic                 do_pop;

    assign full        = (cnt_reg == (PTR_WIDTH+1)'(FIFO_DEPTH));
    assign q_out.valid = (cnt_reg != '0);
    assign q_out.pop   = do_pop;
    assign q_out.head  = mem[rd_reg];
    assign do_pop      = pop && q_out.valid;

    always_comb
    begin
        wr_next  = push ? PTR_WIDTH'((wr_reg + 1'b1) % FIFO_DEPTH) : wr_reg;
        rd_next  = do_pop ? PTR_WIDTH'((rd_reg + 1'b1) % FIFO_DEPTH) : rd_reg;
        cnt_next = cnt_reg + (PTR_WIDTH+1)'(push) - (PTR_WIDTH+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= entry;
    end
endmodule

// ===== hdl/cau_back.sv =====
// Back end: products, sums, pipelined restoring divide, saturation, output register.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_back
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  queue_if_t q_in,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);
    localparam int PW = 2 * DATA_WIDTH;

    typedef struct packed {
        logic [1:0]           op;
        logic                 dz;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] p_yr2;
        logic signed [PW-1:0] p_yi2;
        logic signed [DATA_WIDTH:0] sum_re;
        logic signed [DATA_WIDTH:0] sum_im;
    } prod_t;

    typedef struct packed {
        logic                 is_div;
        logic                 dz;
        logic                 neg_re;
        logic                 neg_im;
        logic [MAG_WIDTH-1:0] mag_re;
        logic [MAG_WIDTH-1:0] mag_im;
        logic [MAG_WIDTH-1:0] den;
    } comb_t;

    typedef struct packed {
        comb_t                c;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [REM_WIDTH-1:0] r_re;
        logic [REM_WIDTH-1:0] r_im;
        logic [QUO_WIDTH-1:0] q_re;
        logic [QUO_WIDTH-1:0] q_im;
    } div_t;

    logic      en;
    logic      v1_reg, v2_reg, out_valid_reg;
    logic      vd_reg [QUO_WIDTH+1];
    prod_t     s1_reg, s1_next;
    comb_t     s2_reg, s2_next;
    div_t      sd_reg [QUO_WIDTH+1];
    div_t      sd_next [QUO_WIDTH+1];
    out_word_t out_reg, out_next;

    assign en        = !out_valid_reg || !out_stall;
    assign pop       = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        in_word_t w;
        w = q_in.head.word;
        s1_next.op     = w.operation;
        s1_next.dz     = q_in.head.div_zero;
        s1_next.p_rr   = PW'(w.x_real * w.y_real);
        s1_next.p_ii   = PW'(w.x_imag * w.y_imag);
        s1_next.p_ri   = PW'(w.x_real * w.y_imag);
        s1_next.p_ir   = PW'(w.x_imag * w.y_real);
        s1_next.p_yr2  = PW'(w.y_real * w.y_real);
        s1_next.p_yi2  = PW'(w.y_imag * w.y_imag);
        if (w.operation == OP_SUB)
        begin
            s1_next.sum_re = (DATA_WIDTH+1)'(w.x_real) - (DATA_WIDTH+1)'(w.y_real);
            s1_next.sum_im = (DATA_WIDTH+1)'(w.x_imag) - (DATA_WIDTH+1)'(w.y_imag);
        end
        else
        begin
            s1_next.sum_re = (DATA_WIDTH+1)'(w.x_real) + (DATA_WIDTH+1)'(w.y_real);
            s1_next.sum_im = (DATA_WIDTH+1)'(w.x_imag) + (DATA_WIDTH+1)'(w.y_imag);
        end
    end

    always_comb
    begin
        logic signed [MAG_WIDTH:0] re_s;
        logic signed [MAG_WIDTH:0] im_s;
        logic [MAG_WIDTH:0]        abs_re;
        logic [MAG_WIDTH:0]        abs_im;
        logic [MAG_WIDTH:0]        d_s;
        unique case (s1_reg.op)
            OP_MUL:
            begin
                re_s = (MAG_WIDTH+1)'(s1_reg.p_rr) - (MAG_WIDTH+1)'(s1_reg.p_ii);
                im_s = (MAG_WIDTH+1)'(s1_reg.p_ri) + (MAG_WIDTH+1)'(s1_reg.p_ir);
            end
            OP_DIV:
            begin
                re_s = (MAG_WIDTH+1)'(s1_reg.p_rr) + (MAG_WIDTH+1)'(s1_reg.p_ii);
                im_s = (MAG_WIDTH+1)'(s1_reg.p_ir) - (MAG_WIDTH+1)'(s1_reg.p_ri);
            end
            default:
            begin
                re_s = (MAG_WIDTH+1)'(s1_reg.sum_re);
                im_s = (MAG_WIDTH+1)'(s1_reg.sum_im);
            end
        endcase
        abs_re = re_s[MAG_WIDTH] ? -re_s : re_s;
        abs_im = im_s[MAG_WIDTH] ? -im_s : im_s;
        d_s    = (MAG_WIDTH+1)'(s1_reg.p_yr2) + (MAG_WIDTH+1)'(s1_reg.p_yi2);
        s2_next.is_div = (s1_reg.op == OP_DIV);
        s2_next.dz     = s1_reg.dz;
        s2_next.neg_re = re_s[MAG_WIDTH];
        s2_next.neg_im = im_s[MAG_WIDTH];
        s2_next.den    = d_s[MAG_WIDTH-1:0];
        if (s1_reg.op == OP_MUL)
        begin
            s2_next.mag_re = abs_re[MAG_WIDTH-1:0] >> FRAC_BITS;
            s2_next.mag_im = abs_im[MAG_WIDTH-1:0] >> FRAC_BITS;
        end
        else
        begin
            s2_next.mag_re = abs_re[MAG_WIDTH-1:0];
            s2_next.mag_im = abs_im[MAG_WIDTH-1:0];
        end
    end

    always_comb
    begin
        logic [REM_WIDTH-1:0] n_re;
        logic [REM_WIDTH-1:0] n_im;
        logic [REM_WIDTH-1:0] d_w;
        n_re = REM_WIDTH'(s2_reg.mag_re) << FRAC_BITS;
        n_im = REM_WIDTH'(s2_reg.mag_im) << FRAC_BITS;
        d_w  = REM_WIDTH'(s2_reg.den);
        sd_next[0].c      = s2_reg;
        sd_next[0].ovf_re = (n_re >> QUO_WIDTH) >= d_w;
        sd_next[0].ovf_im = (n_im >> QUO_WIDTH) >= d_w;
        sd_next[0].r_re   = n_re;
        sd_next[0].r_im   = n_im;
        sd_next[0].q_re   = '0;
        sd_next[0].q_im   = '0;
    end

    for (genvar k = 0; k < QUO_WIDTH; k++)
    begin : g_div
        localparam int SH = QUO_WIDTH - 1 - k;
        always_comb
        begin
            logic [REM_WIDTH-1:0] dk;
            dk = REM_WIDTH'(sd_reg[k].c.den) << SH;
            sd_next[k+1] = sd_reg[k];
            if (sd_reg[k].r_re >= dk)
            begin
                sd_next[k+1].r_re     = sd_reg[k].r_re - dk;
                sd_next[k+1].q_re[SH] = 1'b1;
            end
            if (sd_reg[k].r_im >= dk)
            begin
                sd_next[k+1].r_im     = sd_reg[k].r_im - dk;
                sd_next[k+1].q_im[SH] = 1'b1;
            end
        end
    end

    always_comb
    begin
        div_t                 f;
        logic [MAG_WIDTH-1:0] m_re;
        logic [MAG_WIDTH-1:0] m_im;
        logic                 sat_re;
        logic                 sat_im;
        f = sd_reg[QUO_WIDTH];
        if (f.c.is_div)
        begin
            m_re = f.ovf_re ? '1 : MAG_WIDTH'(f.q_re);
            m_im = f.ovf_im ? '1 : MAG_WIDTH'(f.q_im);
        end
        else
        begin
            m_re = f.c.mag_re;
            m_im = f.c.mag_im;
        end
        sat_re = f.c.neg_re ? (m_re > MAG_WIDTH'(NEG_MIN)) : (m_re > MAG_WIDTH'(POS_MAX));
        sat_im = f.c.neg_im ? (m_im > MAG_WIDTH'(NEG_MIN)) : (m_im > MAG_WIDTH'(POS_MAX));
        if (sat_re)
            out_next.z_real = f.c.neg_re ? NEG_MIN : POS_MAX;
        else
            out_next.z_real = f.c.neg_re ? -m_re[DATA_WIDTH-1:0] : m_re[DATA_WIDTH-1:0];
        if (sat_im)
            out_next.z_imag = f.c.neg_im ? NEG_MIN : POS_MAX;
        else
            out_next.z_imag = f.c.neg_im ? -m_im[DATA_WIDTH-1:0] : m_im[DATA_WIDTH-1:0];
        out_next.status = (sat_re || sat_im) ? ST_SAT : ST_OK;
        if (f.c.dz)
        begin
            out_next.z_real = POS_MAX;
            out_next.z_imag = POS_MAX;
            out_next.status = ST_DZ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= QUO_WIDTH; i++)
                vd_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= q_in.valid;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int i = 1; i <= QUO_WIDTH; i++)
                vd_reg[i] <= vd_reg[i-1];
            out_valid_reg <= vd_reg[QUO_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            for (int i = 0; i <= QUO_WIDTH; i++)
                sd_reg[i] <= sd_next[i];
            out_reg <= out_next;
        end
    end
endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front end, queue, back end.
// Depends on cau_pkg, cau_front, cau_fifo, cau_back.
//
// Usage: in_data carries operation and two complex Q3.12 operands; out_data
// carries the complex result and status (ok, saturated, divide by zero).
// Both channels use valid/stall: a word moves on a rising edge with valid
// high and stall low. Valid never depends on stall.
// Throughput: one word per cycle for every operation while out_stall is low.
// Path from input acceptance to out_valid: one input register, the queue,
// products, sums, divide setup, seventeen restoring divide stages, and the
// output register. Every operation takes the same path so results keep
// input order.
// Reset clears all valid flags and the queue; no results are pending after.
// Back end holds while out_valid and out_stall are both high; the four-word
// queue keeps the front end accepting until it fills, then in_stall rises.
`timescale 1ns / 1ps
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);
    logic      full;
    logic      push;
    logic      pop;
    entry_t    entry;
    queue_if_t q_if;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .full     (full),
        .push     (push),
        .entry    (entry)
    );

    cau_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .entry (entry),
        .full  (full),
        .q_out (q_if),
        .pop   (pop)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_in      (q_if),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK || out_data.status == ST_SAT ||
                       out_data.status == ST_DZ))
        else $error("status code out of range");

    a_dz_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_DZ) |->
        (out_data.z_real == POS_MAX && out_data.z_imag == POS_MAX))
        else $error("divide by zero result not saturated high");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
endmodule
